### hdl/assert_macros.svh
// Shared assertion macros for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same, without reset gating.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/bfba_pkg.sv
`default_nettype none
package bfba_pkg;
  localparam int AW       = 24;
  localparam int FREE_N   = 64;
  localparam int USED_N   = 64;
  localparam int FIW      = $clog2(FREE_N);
  localparam int UIW      = $clog2(USED_N);
  localparam int SCAN_N   = (FREE_N > USED_N) ? FREE_N : USED_N;
  localparam int CW       = $clog2(SCAN_N + 1);

  localparam logic [AW-1:0] POOL_RESET    = 24'd6291456;
  localparam logic [3:0]    GRANULE_RESET = 4'd7;
  localparam logic [3:0]    GRANULE_MAX   = 4'd12;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_COAL  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_FIT   = 2'd1;
  localparam logic [1:0] STAT_NOT_USED = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  localparam logic REG_POOL    = 1'b0;
  localparam logic REG_GRANULE = 1'b1;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic [AW-1:0] size;
  } ent_t;
endpackage
`default_nettype wire

### hdl/best_fit_block_allocator.sv
`default_nettype none
// Best-fit allocator over a configurable pool, with explicit coalesce passes.
// Request channel: in_valid/in_stall carry func, req_size and req_address.
// Result channel: out_valid/out_stall carry block_address, block_size,
// status and merged_any; every request yields exactly one result beat.
// A beat moves at a clock edge where valid is high and stall is low.
// The block takes one request at a time: in_stall is high from the accept
// until the result is loaded into the output register.
// Allocate and free make one pass over the tables; a zero-size allocate
// or func code 3 skips the pass. A coalesce runs one table pass per step
// of its address walk, then a last pass that finds no block above the
// threshold. The free and used memories are scanned together, one entry
// of each a cycle. A stalled result holds in the output register; a
// finished request waits for that register before the next request is
// taken. Reset (rst, synchronous) and any write on the APB port reset
// the tables to one free block spanning the pool (none if it is zero);
// the user must write config only when idle, as the block does not
// enforce it.
module best_fit_block_allocator
  import bfba_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    func,
  input  wire logic [AW-1:0] req_size,
  input  wire logic [AW-1:0] req_address,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic      [AW-1:0] block_address,
  output logic      [AW-1:0] block_size,
  output logic      [1:0]    status,
  output logic               merged_any
);
`include "assert_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  // configuration
  logic [AW-1:0] pool_bytes;
  logic [3:0]    granule_log2;
  logic          cfg_wr;
  logic [AW-1:0] pool_new;
  logic          init;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_POOL) ? {8'd0, pool_bytes} : {28'd0, granule_log2};
  assign init   = rst || cfg_wr;

  always_comb begin
    if (rst) begin
      pool_new = POOL_RESET;
    end else if (cfg_wr && paddr[2] == REG_POOL) begin
      pool_new = pwdata[AW-1:0];
    end else begin
      pool_new = pool_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_bytes   <= POOL_RESET;
      granule_log2 <= GRANULE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_POOL) begin
        pool_bytes <= pwdata[AW-1:0];
      end else begin
        granule_log2 <= pwdata[3:0];
      end
    end
  end

  // round the request up to the granule
  logic [3:0]  gl;
  logic [11:0] gmask;
  logic [AW:0] round_in;
  assign gl       = (granule_log2 > GRANULE_MAX) ? GRANULE_MAX : granule_log2;
  assign gmask    = 12'((13'd1 << gl) - 13'd1);
  assign round_in = (({1'b0, req_size} + {13'd0, gmask}) & ~{13'd0, gmask});

  // control state
  logic [1:0]    state;
  logic [1:0]    op;
  logic [CW-1:0] cnt;
  logic [CW-1:0] p_idx;
  logic          p_vld;
  logic          found;
  logic          slot_found;
  logic [CW-1:0] best_idx;
  logic [CW-1:0] slot;
  logic [AW-1:0] best_addr;
  logic [AW-1:0] best_size;
  logic [FIW-1:0] cur_idx;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] cur_size;
  logic          want_cur;
  logic          has_thr;
  logic [AW-1:0] thr;
  logic          merged;
  logic [AW:0]   round;
  logic [AW-1:0] req_addr;
  logic [AW-1:0] res_addr;
  logic [AW-1:0] res_size;
  logic [1:0]    res_status;
  logic          res_merged;

  // tables: entries in memories, valid bits in flops
  ent_t fmem [FREE_N];
  ent_t umem [USED_N];
  ent_t frd;
  ent_t urd;
  logic [FREE_N-1:0] free_valid;
  logic [USED_N-1:0] used_valid;

  logic           fwe, uwe;
  logic [FIW-1:0] fwa;
  logic [UIW-1:0] uwa;
  ent_t           fwd, uwd;

  always_ff @(posedge clk) begin
    if (fwe) begin
      fmem[fwa] <= fwd;
    end
    frd <= fmem[cnt[FIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (uwe) begin
      umem[uwa] <= uwd;
    end
    urd <= umem[cnt[UIW-1:0]];
  end

  // per-entry compare on the entry read last cycle
  logic f_ok, u_ok, fv, uv;
  logic alloc_cand, coal_cand, free_match, alloc_slot, free_slot;
  logic scan_end, dec, split, merge_now, alloc_ok, free_ok;

  assign f_ok = p_idx < CW'(FREE_N);
  assign u_ok = p_idx < CW'(USED_N);
  assign fv   = f_ok && free_valid[p_idx[FIW-1:0]];
  assign uv   = u_ok && used_valid[p_idx[UIW-1:0]];

  assign alloc_cand = fv && ({1'b0, frd.size} >= round) &&
                      (!found || frd.size < best_size ||
                       (frd.size == best_size && frd.addr < best_addr));
  assign coal_cand  = fv && (!has_thr || frd.addr > thr) &&
                      (!found || frd.addr < best_addr);
  assign free_match = uv && urd.addr == req_addr && !found;
  assign alloc_slot = u_ok && !uv && !slot_found;
  assign free_slot  = f_ok && !fv && !slot_found;

  assign scan_end  = (cnt == CW'(SCAN_N)) && !p_vld;
  assign dec       = (state == S_SCAN) && scan_end;
  assign split     = best_size != round[AW-1:0];
  assign alloc_ok  = found && slot_found;
  assign free_ok   = found && slot_found;
  assign merge_now = !want_cur && found && ((best_addr - cur_addr) == cur_size);

  // table writes
  always_comb begin
    fwe = 1'b0;
    fwa = '0;
    fwd = '0;
    uwe = 1'b0;
    uwa = '0;
    uwd = '0;
    if (init) begin
      fwe = 1'b1;
      fwd = '{addr: '0, size: pool_new};
    end else if (dec) begin
      unique case (op)
        FUNC_ALLOC: begin
          if (alloc_ok) begin
            uwe = 1'b1;
            uwa = slot[UIW-1:0];
            uwd = '{addr: best_addr, size: round[AW-1:0]};
            fwe = split;
            fwa = best_idx[FIW-1:0];
            fwd = '{addr: best_addr + round[AW-1:0], size: best_size - round[AW-1:0]};
          end
        end
        FUNC_FREE: begin
          if (free_ok) begin
            fwe = 1'b1;
            fwa = slot[FIW-1:0];
            fwd = '{addr: best_addr, size: best_size};
          end
        end
        FUNC_COAL: begin
          if (merge_now) begin
            fwe = 1'b1;
            fwa = cur_idx;
            fwd = '{addr: cur_addr, size: cur_size + best_size};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      free_valid <= {{(FREE_N-1){1'b0}}, pool_new != '0};
      used_valid <= '0;
    end else if (dec) begin
      unique case (op)
        FUNC_ALLOC: begin
          if (alloc_ok) begin
            used_valid[slot[UIW-1:0]] <= 1'b1;
            if (!split) begin
              free_valid[best_idx[FIW-1:0]] <= 1'b0;
            end
          end
        end
        FUNC_FREE: begin
          if (free_ok) begin
            free_valid[slot[FIW-1:0]]     <= 1'b1;
            used_valid[best_idx[UIW-1:0]] <= 1'b0;
          end
        end
        FUNC_COAL: begin
          if (merge_now) begin
            free_valid[best_idx[FIW-1:0]] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall = state != S_IDLE;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      p_vld     <= 1'b0;
      cnt       <= '0;
    end else begin
      // drop a taken beat unless a new one loads this cycle
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= func;
            round      <= round_in;
            req_addr   <= req_address;
            cnt        <= '0;
            p_vld      <= 1'b0;
            found      <= 1'b0;
            slot_found <= 1'b0;
            has_thr    <= 1'b0;
            want_cur   <= 1'b1;
            merged     <= 1'b0;
            res_addr   <= '0;
            res_size   <= '0;
            res_merged <= 1'b0;
            res_status <= (func == FUNC_ALLOC && round_in == '0) ? STAT_NO_FIT : STAT_OK;
            if (func == FUNC_ALLOC && round_in == '0) begin
              state <= S_FIN;
            end else if (func != FUNC_ALLOC && func != FUNC_FREE && func != FUNC_COAL) begin
              state <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // issue one read a cycle, judge it the cycle after
          if (cnt < CW'(SCAN_N)) begin
            cnt   <= cnt + 1'b1;
            p_vld <= 1'b1;
            p_idx <= cnt;
          end else begin
            p_vld <= 1'b0;
          end
          if (p_vld) begin
            unique case (op)
              FUNC_ALLOC: begin
                if (alloc_cand) begin
                  found     <= 1'b1;
                  best_idx  <= p_idx;
                  best_addr <= frd.addr;
                  best_size <= frd.size;
                end
                if (alloc_slot) begin
                  slot_found <= 1'b1;
                  slot       <= p_idx;
                end
              end
              FUNC_FREE: begin
                if (free_match) begin
                  found     <= 1'b1;
                  best_idx  <= p_idx;
                  best_addr <= urd.addr;
                  best_size <= urd.size;
                end
                if (free_slot) begin
                  slot_found <= 1'b1;
                  slot       <= p_idx;
                end
              end
              default: begin
                if (coal_cand) begin
                  found     <= 1'b1;
                  best_idx  <= p_idx;
                  best_addr <= frd.addr;
                  best_size <= frd.size;
                end
              end
            endcase
          end
          if (scan_end) begin
            unique case (op)
              FUNC_ALLOC: begin
                state <= S_FIN;
                if (!found) begin
                  res_status <= STAT_NO_FIT;
                end else if (!slot_found) begin
                  res_status <= STAT_FULL;
                end else begin
                  res_addr <= best_addr;
                  res_size <= round[AW-1:0];
                end
              end
              FUNC_FREE: begin
                state <= S_FIN;
                if (!found) begin
                  res_status <= STAT_NOT_USED;
                end else if (!slot_found) begin
                  res_status <= STAT_FULL;
                end else begin
                  res_addr <= best_addr;
                  res_size <= best_size;
                end
              end
              default: begin
                if (!found) begin
                  res_merged <= merged;
                  state      <= S_FIN;
                end else begin
                  // step the address walk and rescan above the new threshold
                  cnt     <= '0;
                  found   <= 1'b0;
                  has_thr <= 1'b1;
                  thr     <= best_addr;
                  if (merge_now) begin
                    merged   <= 1'b1;
                    want_cur <= 1'b1;
                  end else begin
                    cur_idx  <= best_idx[FIW-1:0];
                    cur_addr <= best_addr;
                    cur_size <= best_size;
                    want_cur <= 1'b0;
                  end
                end
              end
            endcase
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            block_address <= res_addr;
            block_size    <= res_size;
            status        <= res_status;
            merged_any    <= res_merged;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_accept_busy, clk, rst, in_valid && !in_stall |=> state != S_IDLE, "accepted request left sequencer idle")
  `ASSERT_CLK(a_used_step, clk, rst, !cfg_wr |=> $countones(used_valid) <= $past($countones(used_valid)) + 1, "used table grew by more than one")
  `ASSERT_CLK(a_merge_ok, clk, rst, out_valid && merged_any |-> status == STAT_OK && block_address == '0, "merge flag on a non-coalesce result")

endmodule
`default_nettype wire

### test/best_fit_block_allocator_tb.sv
`default_nettype none
module best_fit_block_allocator_tb;
  import bfba_pkg::*;

  // Unused request code; the block must answer it with an all-zero beat.
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct {
    bit          live;
    bit [AW-1:0] base;
    bit [AW-1:0] len;
  } blk_t;

  typedef struct {
    bit [AW-1:0] base;
    bit [AW-1:0] len;
    bit [1:0]    stat;
    bit          merged;
  } grant_t;

  logic          clk;
  logic          rst;
  logic          psel, penable, pwrite, pready;
  logic [2:0]    paddr;
  logic [31:0]   pwdata, prdata;
  logic          in_valid, in_stall, out_valid, out_stall;
  logic [1:0]    func, status;
  logic [AW-1:0] req_size, req_address, block_address, block_size;
  logic          merged_any;

  best_fit_block_allocator u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .req_size(req_size), .req_address(req_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .block_address(block_address), .block_size(block_size),
    .status(status), .merged_any(merged_any)
  );

  // Shadow of the allocator: pool settings plus both block tables.
  bit [AW-1:0] pool_sz;
  bit [3:0]    gran_log2;
  blk_t        free_blk[FREE_N];
  blk_t        used_blk[USED_N];

  grant_t grant_q[$];
  int     mismatches;
  int     beats_checked;
  int     coalesce_merges;
  bit     quiet;            // no idling on either side once set
  int     stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous ceiling: worst case is every beat a full-table coalesce pass.
  initial begin
    #100000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Rebuild both tables as one free block over the whole pool.
  function automatic void tables_init();
    foreach (free_blk[i]) free_blk[i] = '{0, 0, 0};
    foreach (used_blk[i]) used_blk[i] = '{0, 0, 0};
    if (pool_sz != 0) free_blk[0] = '{1, 0, pool_sz};
  endfunction

  function automatic grant_t alloc_predict(bit [AW-1:0] want);
    bit [3:0]  g;
    bit [AW:0] mask, rnd;
    int        best, slot;
    g = (gran_log2 > GRANULE_MAX) ? GRANULE_MAX : gran_log2;
    mask = (25'd1 << g) - 25'd1;
    rnd = ({1'b0, want} + mask) & ~mask;
    best = -1;
    slot = -1;
    if (rnd == 0) return '{0, 0, STAT_NO_FIT, 0};
    for (int i = 0; i < FREE_N; i++) begin
      if (!free_blk[i].live || {1'b0, free_blk[i].len} < rnd) continue;
      if (best < 0 || free_blk[i].len < free_blk[best].len ||
          (free_blk[i].len == free_blk[best].len &&
           free_blk[i].base < free_blk[best].base))
        best = i;
    end
    if (best < 0) return '{0, 0, STAT_NO_FIT, 0};
    for (int i = 0; i < USED_N; i++)
      if (!used_blk[i].live) begin
        slot = i;
        break;
      end
    if (slot < 0) return '{0, 0, STAT_FULL, 0};
    used_blk[slot] = '{1, free_blk[best].base, rnd[AW-1:0]};
    if (free_blk[best].len == rnd[AW-1:0]) free_blk[best].live = 0;
    else begin
      free_blk[best].base += rnd[AW-1:0];
      free_blk[best].len  -= rnd[AW-1:0];
    end
    return '{used_blk[slot].base, rnd[AW-1:0], STAT_OK, 0};
  endfunction

  function automatic grant_t release_predict(bit [AW-1:0] where);
    int u, f;
    u = -1;
    f = -1;
    for (int i = 0; i < USED_N; i++)
      if (used_blk[i].live && used_blk[i].base == where) begin
        u = i;
        break;
      end
    if (u < 0) return '{0, 0, STAT_NOT_USED, 0};
    for (int i = 0; i < FREE_N; i++)
      if (!free_blk[i].live) begin
        f = i;
        break;
      end
    if (f < 0) return '{0, 0, STAT_FULL, 0};
    free_blk[f] = used_blk[u];
    used_blk[u].live = 0;
    return '{free_blk[f].base, free_blk[f].len, STAT_OK, 0};
  endfunction

  function automatic grant_t coalesce_predict();
    int ord[$];
    int j, k;
    bit hit;
    hit = 0;
    // Stable insertion sort of live free blocks by address.
    for (int i = 0; i < FREE_N; i++) begin
      if (!free_blk[i].live) continue;
      j = ord.size();
      while (j > 0 && free_blk[ord[j-1]].base > free_blk[i].base) j--;
      ord.insert(j, i);
    end
    k = 0;
    while (k + 1 < ord.size()) begin
      if (free_blk[ord[k+1]].base - free_blk[ord[k]].base == free_blk[ord[k]].len) begin
        free_blk[ord[k]].len += free_blk[ord[k+1]].len;
        free_blk[ord[k+1]].live = 0;
        hit = 1;
        k += 2;
      end else k += 1;
    end
    return '{0, 0, STAT_OK, hit};
  endfunction

  function automatic grant_t request_predict(bit [1:0] f, bit [AW-1:0] sz,
                                             bit [AW-1:0] ad);
    case (f)
      FUNC_ALLOC: return alloc_predict(sz);
      FUNC_FREE:  return release_predict(ad);
      FUNC_COAL:  return coalesce_predict();
      default:    return '{0, 0, STAT_OK, 0};
    endcase
  endfunction

  // Address of some block currently held, or a random offset if none.
  function automatic bit [AW-1:0] held_address();
    int picks[$];
    foreach (used_blk[i]) if (used_blk[i].live) picks.push_back(i);
    if (picks.size() == 0) return AW'($urandom());
    return used_blk[picks[$urandom_range(0, picks.size() - 1)]].base;
  endfunction

  // Send one request beat; called in the context of a rising edge.
  task automatic send_request(bit [1:0] f, bit [AW-1:0] sz, bit [AW-1:0] ad);
    func        <= f;
    req_size    <= sz;
    req_address <= ad;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    grant_q.push_back(request_predict(f, sz, ad));
    // Drop valid for a short burst now and then.
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drain outstanding results, then write one register over APB.
  task automatic write_reg(logic idx, bit [31:0] val);
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_POOL) pool_sz = val[AW-1:0];
    else gran_log2 = val[3:0];
    tables_init();
    @(posedge clk);
  endtask

  // Extremes of each field, every request code and each corner case.
  task automatic test_directed();
    send_request(FUNC_COAL, 0, 0);              // single free block: no merge
    send_request(FUNC_ALLOC, 0, 0);             // zero size: no fit
    send_request(FUNC_ALLOC, 24'hFFFFFF, 0);    // rounds past the pool
    send_request(FUNC_NONE, 24'hFFFFFF, 24'hFFFFFF);
    send_request(FUNC_FREE, 0, 24'hFFFFFF);     // nothing held: unknown
    send_request(FUNC_ALLOC, 1, 0);
    send_request(FUNC_ALLOC, 129, 0);
    send_request(FUNC_ALLOC, 128, 0);
    send_request(FUNC_FREE, 0, 0);
    send_request(FUNC_FREE, 0, 0);              // double free
    send_request(FUNC_FREE, 0, 128);
    send_request(FUNC_COAL, 0, 0);
    send_request(FUNC_COAL, 0, 0);
    send_request(FUNC_ALLOC, 24'd6291456 - 24'd384, 0);
    send_request(FUNC_ALLOC, 24'd384, 0);       // exact fit into the merged block at 0
    send_request(FUNC_ALLOC, 1, 0);
    send_request(FUNC_FREE, 0, 24'd384);
    send_request(FUNC_ALLOC, 24'd6291456 - 24'd384, 0);  // no fit: larger than any free block
    write_reg(REG_POOL, 0);
    send_request(FUNC_ALLOC, 1, 0);             // empty pool
    send_request(FUNC_COAL, 0, 0);
    write_reg(REG_POOL, 24'd1000);
    write_reg(REG_GRANULE, 4'd15);              // clamps to the top granule
    send_request(FUNC_ALLOC, 4096, 0);
    send_request(FUNC_ALLOC, 1000, 0);          // rounds past the short pool: no fit
  endtask

  // Mixed traffic: mostly allocate and free of held blocks, some noise.
  task automatic test_random_mix(int beats, bit [AW-1:0] max_req);
    int pick;
    bit [AW-1:0] sz;
    for (int n = 0; n < beats; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        sz = ($urandom_range(0, 9) == 0) ? AW'($urandom()) : AW'($urandom_range(1, max_req));
        send_request(FUNC_ALLOC, sz, AW'($urandom()));
      end else if (pick < 85) begin
        send_request(FUNC_FREE, AW'($urandom()),
                     ($urandom_range(0, 4) == 0) ? AW'($urandom()) : held_address());
      end else if (pick < 97) send_request(FUNC_COAL, AW'($urandom()), AW'($urandom()));
      else send_request(FUNC_NONE, AW'($urandom()), AW'($urandom()));
    end
  endtask

  // Fragment the pool: fill the used table, then free random held blocks.
  task automatic test_table_full(bit [AW-1:0] max_req);
    for (int n = 0; n < USED_N + 4; n++)
      send_request(FUNC_ALLOC, AW'($urandom_range(1, max_req)), 0);
    for (int n = 0; n < USED_N + 4; n++)
      send_request(FUNC_FREE, 0, held_address());
    send_request(FUNC_COAL, 0, 0);
  endtask

  task automatic test_config_sweep();
    write_reg(REG_POOL, 24'd6291456);
    write_reg(REG_GRANULE, 4'd7);
    test_random_mix(200, 24'd200000);
    write_reg(REG_GRANULE, 4'd0);
    write_reg(REG_POOL, 24'hFFFFFF);
    test_random_mix(200, 24'd300000);
    test_table_full(24'd1000);
    write_reg(REG_GRANULE, 4'd12);
    test_random_mix(200, 24'd100000);
    write_reg(REG_POOL, 24'd0);
    test_random_mix(40, 24'd1000);
    write_reg(REG_POOL, 24'd4097);
    write_reg(REG_GRANULE, 4'd4);
    test_random_mix(200, 24'd200);
    write_reg(REG_POOL, 24'd1000);
    write_reg(REG_GRANULE, 4'd2);
    test_random_mix(200, 24'd40);
    quiet = 1;
    write_reg(REG_POOL, 24'd65536);
    write_reg(REG_GRANULE, 4'd8);
    test_random_mix(220, 24'd3000);
  endtask

  // Random result-side stall bursts, off once quiet is set.
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: addr %h size %h st %0d",
                                       block_address, block_size, status);
      end else begin
        exp_g = grant_q.pop_front();
        beats_checked++;
        if (exp_g.merged) coalesce_merges++;
        if (block_address !== exp_g.base || block_size !== exp_g.len ||
            status !== exp_g.stat || merged_any !== exp_g.merged) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: exp addr %h size %h st %0d mg %0d, got %h %h %0d %0d",
                     beats_checked, exp_g.base, exp_g.len, exp_g.stat, exp_g.merged,
                     block_address, block_size, status, merged_any);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; func = 0; req_size = 0; req_address = 0;
    out_stall = 0;
    quiet = 0;
    stall_left = 0;
    mismatches = 0;
    beats_checked = 0;
    coalesce_merges = 0;
    pool_sz = POOL_RESET;
    gran_log2 = GRANULE_RESET;
    tables_init();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("checked %0d result beats over directed corners and a sweep of pool settings",
             beats_checked);
    $display("%0d coalesce passes merged at least one pair", coalesce_merges);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
